// ===== design/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// Types, codes and widths shared by the route request ring search block.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int unsigned TTL_W   = 8;
	localparam int unsigned RETRY_W = 4;
	localparam int unsigned NODE_W  = 10;
	localparam int unsigned TBUF_W  = 4;
	localparam int unsigned NET_W   = 16;
	localparam int unsigned SEQ_W   = 32;
	localparam int unsigned CFG_AW  = 3;
	localparam int unsigned CFG_DW  = 16;

	typedef logic [TTL_W-1:0]   ttl_t;
	typedef logic [RETRY_W-1:0] retry_t;
	typedef logic [SEQ_W-1:0]   seq_t;
	typedef logic [CFG_DW-1:0]  cfg_data_t;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_TICK   = 2'd1,
		OP_REPLY  = 2'd2,
		OP_ANSWER = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_BCAST   = 2'd0,
		KIND_FAIL    = 2'd1,
		KIND_SUCCESS = 2'd2,
		KIND_DEST    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_HOLD   = 2'd2
	} mode_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_TTL_START   = 3'd0,
		REG_TTL_INC     = 3'd1,
		REG_TTL_THRESH  = 3'd2,
		REG_NET_DIAM    = 3'd3,
		REG_RETRY_LIMIT = 3'd4,
		REG_NODE_TRAV   = 3'd5,
		REG_TIMEOUT_BUF = 3'd6,
		REG_NET_TRAV    = 3'd7
	} cfg_reg_t;

endpackage

// ===== design/route_request_ring_search_top.sv =====
// ----------------------------------------------------------------------------
// route_request_ring_search_top
// Expanding ring route discovery sequencer for one destination.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transaction: start
//   search, one millisecond tick, reply arrived, or answer as destination.
//   Output channel (out_valid/out_ready) carries at most one result per event:
//   a broadcast request, a failure or dropped start, a success, or a
//   destination reply. Events that cause nothing produce no transaction.
//   An accepted event is held in the input register, and its result is loaded
//   into the output register when the event advances.
//   Throughput: one event per cycle while the receiver is ready; the ring time
//   multiply (10 x 10 bits) and the wait counter decrement are the longest
//   paths between the two registers.
//   When the receiver stalls, the pending result is held in the output
//   register and one further event waits in the input register; in_ready drops
//   only once both are occupied.
//   Reset (arst_n low) clears the search state and the counters, empties both
//   registers and loads the configuration defaults. Configuration writes via
//   cfg_wen/cfg_index/cfg_data take effect at once; the user must make them while idle, unchecked by the block.
// ----------------------------------------------------------------------------
module route_request_ring_search_top (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_wen,
	input  logic [2:0]             cfg_index,
	input  rrs_pkg::cfg_data_t     cfg_data,
	// event channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  rrs_pkg::ttl_t          known_hop_count,
	input  logic                   seq_known,
	input  rrs_pkg::seq_t          peer_seq,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             kind,
	output rrs_pkg::ttl_t          ttl,
	output rrs_pkg::seq_t          request_id,
	output rrs_pkg::seq_t          own_seq,
	output rrs_pkg::seq_t          dest_seq_out,
	output logic                   unknown_flag,
	output rrs_pkg::seq_t          wait_ms
);
	import rrs_pkg::*;

	// configuration registers
	ttl_t              ttl_start_q, ttl_inc_q, ttl_thresh_q, net_diam_q;
	retry_t            retry_limit_q;
	logic [NODE_W-1:0] node_trav_q;
	logic [TBUF_W-1:0] timeout_buf_q;
	logic [NET_W-1:0]  net_trav_q;

	// search state
	mode_t  mode_q, mode_n;
	logic   diam_q, diam_n;
	ttl_t   cur_ttl_q, cur_ttl_n;
	retry_t retry_q, retry_n;
	seq_t   wait_q, wait_n;
	seq_t   own_q, own_n;
	seq_t   req_q, req_n;
	seq_t   saved_dest_q, saved_dest_n;
	logic   saved_unk_q, saved_unk_n;

	// input register
	logic  valid_s1;
	op_t   op_s1;
	ttl_t  hop_s1;
	logic  known_s1;
	seq_t  peer_s1;

	// output register
	logic  out_valid_q;
	kind_t kind_q;
	ttl_t  ttl_q;
	seq_t  req_id_q, own_seq_q, dest_q, wait_ms_q;
	logic  unk_q;

	logic advance;

	// Take a new transaction whenever the input register is empty or drains now.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// ------------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_start_q   <= TTL_W'(1);
			ttl_inc_q     <= TTL_W'(2);
			ttl_thresh_q  <= TTL_W'(7);
			net_diam_q    <= TTL_W'(35);
			retry_limit_q <= RETRY_W'(2);
			node_trav_q   <= NODE_W'(40);
			timeout_buf_q <= TBUF_W'(2);
			net_trav_q    <= NET_W'(2800);
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TTL_START:   ttl_start_q   <= cfg_data[TTL_W-1:0];
				REG_TTL_INC:     ttl_inc_q     <= cfg_data[TTL_W-1:0];
				REG_TTL_THRESH:  ttl_thresh_q  <= cfg_data[TTL_W-1:0];
				REG_NET_DIAM:    net_diam_q    <= cfg_data[TTL_W-1:0];
				REG_RETRY_LIMIT: retry_limit_q <= cfg_data[RETRY_W-1:0];
				REG_NODE_TRAV:   node_trav_q   <= cfg_data[NODE_W-1:0];
				REG_TIMEOUT_BUF: timeout_buf_q <= cfg_data[TBUF_W-1:0];
				REG_NET_TRAV:    net_trav_q    <= cfg_data[NET_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= op_t'(op);
			hop_s1   <= known_hop_count;
			known_s1 <= seq_known;
			peer_s1  <= peer_seq;
		end
	end

	// ------------------------------------------------------------------------
	// Datapath helpers
	// ------------------------------------------------------------------------
	logic [TTL_W:0]    start_ttl, next_ttl, ring_ttl;
	logic [TTL_W+1:0]  ring_hops;
	logic [NODE_W+TTL_W+2:0] ring_wait;
	logic              start_in_ring, next_in_ring;
	retry_t            retry_inc;
	seq_t              retry_wait, hold_wait, wait_dec, answer_seq, own_inc, seq_diff;

	// First TTL: configured start if above the known hop count, else grow past it.
	assign start_ttl = (ttl_start_q > hop_s1) ? {1'b0, ttl_start_q}
	                                          : {1'b0, hop_s1} + {1'b0, ttl_inc_q};
	assign next_ttl  = {1'b0, cur_ttl_q} + {1'b0, ttl_inc_q};
	assign start_in_ring = start_ttl <= {1'b0, ttl_thresh_q};
	assign next_in_ring  = next_ttl  <= {1'b0, ttl_thresh_q};

	// Ring wait 2 * node traversal * (ttl + timeout buffer), one shared multiplier.
	assign ring_ttl  = (op_s1 == OP_START) ? start_ttl : next_ttl;
	assign ring_hops = {1'b0, ring_ttl} + (TTL_W+2)'(timeout_buf_q);
	assign ring_wait = {((NODE_W+TTL_W+2)'(node_trav_q) * (NODE_W+TTL_W+2)'(ring_hops)), 1'b0};

	assign retry_inc  = retry_q + RETRY_W'(1);
	assign retry_wait = SEQ_W'(net_trav_q) << retry_inc;
	assign hold_wait  = {SEQ_W'(net_trav_q)} << 1;
	assign wait_dec   = (wait_q != '0) ? wait_q - SEQ_W'(1) : '0;

	// Serial number compare: peer is newer when peer - (own + 1) has top bit clear.
	assign own_inc    = own_q + SEQ_W'(1);
	assign seq_diff   = peer_s1 - own_inc;
	assign answer_seq = (known_s1 && !seq_diff[SEQ_W-1]) ? peer_s1 : own_inc;

	// ------------------------------------------------------------------------
	// Next state and result
	// ------------------------------------------------------------------------
	logic  res_valid;
	kind_t res_kind;
	logic  bcast;
	ttl_t  bcast_ttl;
	seq_t  bcast_wait;

	always_comb begin
		mode_n       = mode_q;
		diam_n       = diam_q;
		cur_ttl_n    = cur_ttl_q;
		retry_n      = retry_q;
		wait_n       = wait_q;
		own_n        = own_q;
		req_n        = req_q;
		saved_dest_n = saved_dest_q;
		saved_unk_n  = saved_unk_q;
		res_valid    = 1'b0;
		res_kind     = KIND_FAIL;
		bcast        = 1'b0;
		bcast_ttl    = '0;
		bcast_wait   = '0;

		if (advance) begin
			unique case (op_s1)
				OP_START: begin
					if (mode_q == MODE_HOLD) begin
						// drop the start during hold-off
						res_valid = 1'b1;
						res_kind  = KIND_FAIL;
					end else if (mode_q == MODE_IDLE) begin
						own_n        = own_inc;
						saved_dest_n = known_s1 ? peer_s1 : '0;
						saved_unk_n  = !known_s1;
						mode_n       = MODE_SEARCH;
						retry_n      = '0;
						bcast        = 1'b1;
						if (start_in_ring) begin
							diam_n     = 1'b0;
							bcast_ttl  = start_ttl[TTL_W-1:0];
							bcast_wait = SEQ_W'(ring_wait);
						end else begin
							diam_n     = 1'b1;
							bcast_ttl  = net_diam_q;
							bcast_wait = SEQ_W'(net_trav_q);
						end
					end
				end
				OP_TICK: begin
					if (mode_q != MODE_IDLE) begin
						wait_n = wait_dec;
						if (wait_dec == '0) begin
							if (mode_q == MODE_HOLD) begin
								mode_n = MODE_IDLE;
							end else if (!diam_q) begin
								bcast = 1'b1;
								if (next_in_ring) begin
									bcast_ttl  = next_ttl[TTL_W-1:0];
									bcast_wait = SEQ_W'(ring_wait);
								end else begin
									diam_n     = 1'b1;
									retry_n    = '0;
									bcast_ttl  = net_diam_q;
									bcast_wait = SEQ_W'(net_trav_q);
								end
							end else if (retry_q < retry_limit_q) begin
								retry_n    = retry_inc;
								bcast      = 1'b1;
								bcast_ttl  = net_diam_q;
								bcast_wait = retry_wait;
							end else begin
								// give up and hold off further starts
								mode_n    = MODE_HOLD;
								diam_n    = 1'b0;
								retry_n   = '0;
								wait_n    = hold_wait;
								res_valid = 1'b1;
								res_kind  = KIND_FAIL;
							end
						end
					end
				end
				OP_REPLY: begin
					if (mode_q == MODE_SEARCH) begin
						mode_n    = MODE_IDLE;
						diam_n    = 1'b0;
						retry_n   = '0;
						wait_n    = '0;
						res_valid = 1'b1;
						res_kind  = KIND_SUCCESS;
					end
				end
				OP_ANSWER: begin
					own_n     = answer_seq;
					res_valid = 1'b1;
					res_kind  = KIND_DEST;
				end
				default: ;
			endcase

			if (bcast) begin
				req_n     = req_q + SEQ_W'(1);
				cur_ttl_n = bcast_ttl;
				wait_n    = bcast_wait;
				res_valid = 1'b1;
				res_kind  = KIND_BCAST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			diam_q       <= 1'b0;
			cur_ttl_q    <= '0;
			retry_q      <= '0;
			wait_q       <= '0;
			own_q        <= '0;
			req_q        <= '0;
			saved_dest_q <= '0;
			saved_unk_q  <= 1'b0;
		end else begin
			mode_q       <= mode_n;
			diam_q       <= diam_n;
			cur_ttl_q    <= cur_ttl_n;
			retry_q      <= retry_n;
			wait_q       <= wait_n;
			own_q        <= own_n;
			req_q        <= req_n;
			saved_dest_q <= saved_dest_n;
			saved_unk_q  <= saved_unk_n;
		end
	end

	// ------------------------------------------------------------------------
	// Output register: hold the result until the receiver takes it
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			kind_q    <= res_kind;
			own_seq_q <= own_n;
			ttl_q     <= bcast ? bcast_ttl    : '0;
			req_id_q  <= bcast ? req_n        : '0;
			dest_q    <= bcast ? saved_dest_n : '0;
			unk_q     <= bcast ? saved_unk_n  : 1'b0;
			wait_ms_q <= bcast ? bcast_wait   : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign ttl          = ttl_q;
	assign request_id   = req_id_q;
	assign own_seq      = own_seq_q;
	assign dest_seq_out = dest_q;
	assign unknown_flag = unk_q;
	assign wait_ms      = wait_ms_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	// Idle means no wait is running.
	a_idle_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (wait_q == '0))
		else $error("wait counter running while idle");

	// Diameter phase and retry count only live inside a search.
	a_diam_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_SEARCH) |-> (!diam_q && retry_q == '0))
		else $error("diameter state outside a search");

	// Retries never run past the configured limit.
	a_retry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		diam_q |-> (retry_q <= retry_limit_q))
		else $error("retry index beyond limit");

	// Every broadcast result advances the request counter.
	a_bcast_req: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && bcast) |=> (req_q == $past(req_q) + SEQ_W'(1)))
		else $error("broadcast without request counter advance");

endmodule

// ===== verif/route_request_ring_search_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// route_request_ring_search_top_tb
// Self-checking bench for the expanding ring route discovery sequencer.
// An in-bench model of the search follows every accepted event and queues
// the message it should produce. The result side pops and compares each
// message field by field. Directed tests cover the reset configuration,
// the walk to failure and hold-off, the register extremes and the sequence
// number rules. Random searches then run under four idling regimes.
// ----------------------------------------------------------------------------
module route_request_ring_search_top_tb;

	import rrs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000; // quiet cycles before giving up
	localparam int SETTLE_CYCLES  = 4;    // drain time of both registers plus margin
	localparam int PHASE_EVENTS   = 100;  // random events per idling regime

	// One message on the result channel.
	typedef struct {
		kind_t kind;
		ttl_t  ttl;
		seq_t  request_id;
		seq_t  own_seq;
		seq_t  dst_seqnum;
		logic  unknown;
		seq_t  wait_ms;
	} route_msg_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_wen = 1'b0;
	logic [2:0] cfg_index = '0;
	cfg_data_t cfg_data = '0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	logic [1:0] op = OP_TICK;
	ttl_t      known_hop_count = '0;
	logic      seq_known = 1'b0;
	seq_t      peer_seq = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	logic [1:0] kind;
	ttl_t      ttl;
	seq_t      request_id;
	seq_t      own_seq;
	seq_t      dest_seq_out;
	logic      unknown_flag;
	seq_t      wait_ms;

	// Messages predicted but not yet seen, oldest first.
	route_msg_t msgs_due[$];

	// Search state as the model sees it.
	mode_t      mode_now;
	logic       diam_phase;
	ttl_t       ring_ttl;
	retry_t     retries_done;
	seq_t       ms_left;
	seq_t       own_seqnum;
	seq_t       req_counter;
	seq_t       saved_dst_seq;
	logic       dest_unknown;

	// Register copies.
	ttl_t              cfg_ttl_start;
	ttl_t              cfg_ttl_inc;
	ttl_t              cfg_ttl_thresh;
	ttl_t              cfg_diameter;
	retry_t            cfg_retry_limit;
	logic [NODE_W-1:0] cfg_node_ms;
	logic [TBUF_W-1:0] cfg_tbuf;
	logic [NET_W-1:0]  cfg_net_ms;

	int error_count    = 0;
	int sent_events    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;

	route_request_ring_search_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.known_hop_count (known_hop_count),
		.seq_known       (seq_known),
		.peer_seq        (peer_seq),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.ttl             (ttl),
		.request_id      (request_id),
		.own_seq         (own_seq),
		.dest_seq_out    (dest_seq_out),
		.unknown_flag    (unknown_flag),
		.wait_ms         (wait_ms)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Model of the search
	// ------------------------------------------------------------------------

	task automatic reset_model();
		cfg_ttl_start   = 8'd1;
		cfg_ttl_inc     = 8'd2;
		cfg_ttl_thresh  = 8'd7;
		cfg_diameter    = 8'd35;
		cfg_retry_limit = 4'd2;
		cfg_node_ms     = 10'd40;
		cfg_tbuf        = 4'd2;
		cfg_net_ms      = 16'd2800;
		mode_now       = MODE_IDLE;
		diam_phase     = 1'b0;
		ring_ttl       = '0;
		retries_done   = '0;
		ms_left        = '0;
		own_seqnum     = '0;
		req_counter    = '0;
		saved_dst_seq  = '0;
		dest_unknown   = 1'b0;
	endtask

	// Ring wait: two traversals of (ttl + buffer) hops.
	function automatic seq_t ring_wait(input seq_t hops);
		return 32'd2 * 32'(cfg_node_ms) * (hops + 32'(cfg_tbuf));
	endfunction

	task automatic queue_notice(input kind_t k);
		route_msg_t m;
		m = '{k, '0, '0, own_seqnum, '0, 1'b0, '0};
		msgs_due.push_back(m);
	endtask

	task automatic queue_broadcast(input seq_t hops, input seq_t wait_len);
		route_msg_t m;
		req_counter = req_counter + 1;
		ring_ttl    = hops[7:0];
		ms_left     = wait_len;
		m = '{KIND_BCAST, ring_ttl, req_counter, own_seqnum, saved_dst_seq,
			dest_unknown, wait_len};
		msgs_due.push_back(m);
	endtask

	task automatic begin_diameter();
		diam_phase   = 1'b1;
		retries_done = '0;
		queue_broadcast(32'(cfg_diameter), 32'(cfg_net_ms));
	endtask

	// Advance the model by one accepted event and queue what it causes.
	task automatic advance_discovery(input op_t o, input ttl_t hop, input logic known,
			input seq_t peer);
		seq_t next_ttl;
		seq_t next_seq;
		case (o)
			OP_START: begin
				if (mode_now == MODE_HOLD) begin
					queue_notice(KIND_FAIL);
				end else if (mode_now == MODE_IDLE) begin
					own_seqnum     = own_seqnum + 1;
					saved_dst_seq  = known ? peer : '0;
					dest_unknown   = !known;
					mode_now       = MODE_SEARCH;
					next_ttl = (cfg_ttl_start > hop) ? 32'(cfg_ttl_start)
						: 32'(hop) + 32'(cfg_ttl_inc);
					if (next_ttl <= 32'(cfg_ttl_thresh)) begin
						diam_phase   = 1'b0;
						retries_done = '0;
						queue_broadcast(next_ttl, ring_wait(next_ttl));
					end else begin
						begin_diameter();
					end
				end
			end
			OP_TICK: begin
				if (mode_now != MODE_IDLE) begin
					if (ms_left != 0)
						ms_left = ms_left - 1;
					if (ms_left == 0) begin
						if (mode_now == MODE_HOLD) begin
							mode_now = MODE_IDLE;
						end else if (!diam_phase) begin
							next_ttl = 32'(ring_ttl) + 32'(cfg_ttl_inc);
							if (next_ttl <= 32'(cfg_ttl_thresh))
								queue_broadcast(next_ttl, ring_wait(next_ttl));
							else
								begin_diameter();
						end else if (retries_done < cfg_retry_limit) begin
							retries_done = retries_done + 1;
							queue_broadcast(32'(cfg_diameter),
								32'(cfg_net_ms) << retries_done);
						end else begin
							mode_now     = MODE_HOLD;
							diam_phase   = 1'b0;
							retries_done = '0;
							ms_left      = 32'd2 * 32'(cfg_net_ms);
							queue_notice(KIND_FAIL);
						end
					end
				end
			end
			OP_REPLY: begin
				if (mode_now == MODE_SEARCH) begin
					mode_now     = MODE_IDLE;
					diam_phase   = 1'b0;
					retries_done = '0;
					ms_left      = '0;
					queue_notice(KIND_SUCCESS);
				end
			end
			default: begin
				// serial number comparison: peer wins only if strictly ahead
				next_seq = own_seqnum + 1;
				if (known && (peer - next_seq) < 32'h8000_0000)
					next_seq = peer;
				own_seqnum = next_seq;
				queue_notice(KIND_DEST);
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------------

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input cfg_data_t val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_TTL_START:   cfg_ttl_start   = val[TTL_W-1:0];
			REG_TTL_INC:     cfg_ttl_inc     = val[TTL_W-1:0];
			REG_TTL_THRESH:  cfg_ttl_thresh  = val[TTL_W-1:0];
			REG_NET_DIAM:    cfg_diameter    = val[TTL_W-1:0];
			REG_RETRY_LIMIT: cfg_retry_limit = val[RETRY_W-1:0];
			REG_NODE_TRAV:   cfg_node_ms     = val[NODE_W-1:0];
			REG_TIMEOUT_BUF: cfg_tbuf        = val[TBUF_W-1:0];
			default:         cfg_net_ms      = val[NET_W-1:0];
		endcase
	endtask

	// Only call with the block drained.
	task automatic apply_config(input int t_start, input int t_inc, input int t_thresh,
			input int diam, input int retries, input int node_ms, input int tbuf,
			input int net_ms);
		write_reg(REG_TTL_START,   cfg_data_t'(t_start));
		write_reg(REG_TTL_INC,     cfg_data_t'(t_inc));
		write_reg(REG_TTL_THRESH,  cfg_data_t'(t_thresh));
		write_reg(REG_NET_DIAM,    cfg_data_t'(diam));
		write_reg(REG_RETRY_LIMIT, cfg_data_t'(retries));
		write_reg(REG_NODE_TRAV,   cfg_data_t'(node_ms));
		write_reg(REG_TIMEOUT_BUF, cfg_data_t'(tbuf));
		write_reg(REG_NET_TRAV,    cfg_data_t'(net_ms));
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Present one event; returns in the step of its acceptance with valid
	// still high, so a following event sent without idling keeps it up without a dip.
	task automatic send_event(input op_t o, input ttl_t hop, input logic known,
			input seq_t peer);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		op              <= o;
		known_hop_count <= hop;
		seq_known       <= known;
		peer_seq        <= peer;
		do @(posedge clk); while (in_ready !== 1'b1);
		advance_discovery(o, hop, known, peer);
		sent_events++;
	endtask

	task automatic send_noise(input op_t o);
		send_event(o, ttl_t'($urandom), 1'($urandom), $urandom);
	endtask

	// End any search, sit out a hold-off, then let every message drain.
	task automatic settle_idle();
		if (mode_now == MODE_SEARCH)
			send_noise(OP_REPLY);
		while (mode_now == MODE_HOLD)
			send_noise(OP_TICK);
		in_valid <= 1'b0;
		while (msgs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset configuration: idle tick and reply are dropped, an answer, one ring broadcast, success.
	task automatic test_default_config();
		send_noise(OP_TICK);
		send_noise(OP_REPLY);
		send_event(OP_ANSWER, 8'd0, 1'b0, 32'h0);
		send_event(OP_START, 8'd0, 1'b1, 32'hA5A5_0001);
		send_event(OP_START, 8'hFF, 1'b0, 32'h5A5A_FFFE);  // ignored
		send_noise(OP_TICK);
		send_event(OP_REPLY, 8'd0, 1'b0, 32'h0);
		settle_idle();
	endtask

	// Ring, diameter, one retry, failure, dropped start in hold-off, then idle.
	task automatic test_walk_to_failure();
		apply_config(1, 2, 1, 9, 1, 1, 0, 1);
		send_event(OP_START, 8'd0, 1'b0, 32'hFFFF_FFFF);
		repeat (5) send_noise(OP_TICK);
		send_event(OP_START, 8'd3, 1'b1, 32'h1234_5678);
		while (mode_now != MODE_IDLE)
			send_noise(OP_TICK);
		settle_idle();
	endtask

	// Every register at its top, then at one (retry limit and timeout buffer at zero).
	task automatic test_register_extremes();
		apply_config(255, 255, 255, 255, 15, 1023, 15, 65535);
		send_event(OP_START, 8'd0, 1'b1, 32'h8000_0000);
		send_noise(OP_TICK);
		send_noise(OP_REPLY);
		// known hop count pushes the first TTL past the threshold
		send_event(OP_START, 8'd255, 1'b0, 32'h0);
		send_noise(OP_REPLY);
		settle_idle();
		apply_config(1, 1, 1, 1, 0, 1, 0, 1);
		send_event(OP_START, 8'd0, 1'b1, 32'h7FFF_FFFF);
		while (mode_now != MODE_IDLE)
			send_noise(OP_TICK);
		settle_idle();
	endtask

	// Own sequence number: plain bump, newer peer, older peer, half-way peer, wrap.
	task automatic test_sequence_numbers();
		send_event(OP_ANSWER, 8'd0, 1'b1, own_seqnum + 32'd5);
		send_event(OP_ANSWER, 8'd0, 1'b1, own_seqnum - 32'd3);
		send_event(OP_ANSWER, 8'd0, 1'b1, own_seqnum + 32'h8000_0001);
		// two large steps forward bring the own number to the top of its range
		send_event(OP_ANSWER, 8'd0, 1'b1, own_seqnum + 32'h7FFF_FFFF);
		send_event(OP_ANSWER, 8'd0, 1'b1, 32'hFFFF_FFFF);
		send_event(OP_START, 8'd0, 1'b0, 32'h0);  // own number wraps to zero
		send_noise(OP_REPLY);
		settle_idle();
	endtask

	task automatic pick_random_config();
		apply_config($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 8),
			$urandom_range(1, 255), $urandom_range(0, 3), $urandom_range(1, 2),
			$urandom_range(0, 3), $urandom_range(1, 3));
	endtask

	// One search with random content, cut short by a reply after a random
	// number of ticks unless it has failed first, with stray events mixed in.
	task automatic run_random_search();
		int tick_budget;
		int r;
		ttl_t hop;
		hop = ($urandom_range(1) != 0) ? ttl_t'($urandom_range(0, 8)) : ttl_t'($urandom);
		send_event(OP_START, hop, 1'($urandom), $urandom);
		tick_budget = $urandom_range(0, 80);
		while (mode_now == MODE_SEARCH && tick_budget > 0) begin
			r = $urandom_range(99);
			if (r < 5) begin
				send_event(OP_ANSWER, ttl_t'($urandom), 1'($urandom),
					own_seqnum + $urandom_range(0, 4));
			end else if (r < 9) begin
				send_noise(OP_START);
			end else begin
				send_noise(OP_TICK);
				tick_budget--;
			end
		end
		if (mode_now == MODE_SEARCH)
			send_noise(OP_REPLY);
		while (mode_now == MODE_HOLD) begin
			r = $urandom_range(99);
			if (r < 10)
				send_noise(OP_START);
			else if (r < 15)
				send_noise(OP_ANSWER);
			else
				send_noise(OP_TICK);
		end
		r = $urandom_range(99);
		if (r < 15)
			send_noise(OP_TICK);
		else if (r < 25)
			send_noise(OP_REPLY);
		else if (r < 35)
			send_noise(OP_ANSWER);
	endtask

	task automatic test_random_searches();
		int regime;
		int target;
		for (regime = 0; regime < 4; regime++) begin
			case (regime)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			target = sent_events + PHASE_EVENTS;
			settle_idle();
			pick_random_config();
			while (sent_events < target) begin
				if ($urandom_range(3) == 0) begin
					settle_idle();
					pick_random_config();
				end
				run_random_search();
			end
		end
		settle_idle();
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stalls, checking, watchdog
	// ------------------------------------------------------------------------

	task automatic check_result();
		route_msg_t want;
		if (msgs_due.size() == 0) begin
			report_error($sformatf("unexpected transaction, kind %0d", kind));
			return;
		end
		want = msgs_due.pop_front();
		if (kind !== want.kind)
			report_error($sformatf("kind %0d, want %0d", kind, want.kind));
		if (ttl !== want.ttl)
			report_error($sformatf("ttl %0d, want %0d", ttl, want.ttl));
		if (request_id !== want.request_id)
			report_error($sformatf("request_id %0h, want %0h", request_id, want.request_id));
		if (own_seq !== want.own_seq)
			report_error($sformatf("own_seq %0h, want %0h", own_seq, want.own_seq));
		if (dest_seq_out !== want.dst_seqnum)
			report_error($sformatf("dest_seq_out %0h, want %0h", dest_seq_out,
				want.dst_seqnum));
		if (unknown_flag !== want.unknown)
			report_error($sformatf("unknown_flag %0b, want %0b", unknown_flag,
				want.unknown));
		if (wait_ms !== want.wait_ms)
			report_error($sformatf("wait_ms %0d, want %0d", wait_ms, want.wait_ms));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			check_result();
		// any transaction on either side resets the watchdog
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------------

	initial begin
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_walk_to_failure();
		test_register_extremes();
		test_sequence_numbers();
		test_random_searches();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
